>>> hw/rtl/parallax_spring_line_scroll_macros.svh
`ifndef PARALLAX_SPRING_LINE_SCROLL_MACROS_SVH
`define PARALLAX_SPRING_LINE_SCROLL_MACROS_SVH

// implication checked in the same cycle, disabled during reset
`define PSLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked after the delay given by dly
`define PSLS_ASSERT_AFTER(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/psls_pkg.sv
`default_nettype none

package psls_pkg;

	localparam int FULL_SPEED = 64;
	localparam int GROUP_COUNT = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_INDEX_W = 3;

	// function codes of an input transaction
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_PULSE = 2'd1;
	localparam logic [1:0] FUNC_STACK = 2'd2;
	localparam logic [1:0] FUNC_QUERY = 2'd3;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_SOFT = 2'd1;
	localparam logic [1:0] KIND_SOFTDROP = 2'd2;
	localparam logic [1:0] KIND_HARDDROP = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DAMPING = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_IMP_SOFT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_IMP_SOFTDROP = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_IMP_HARDDROP = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_REST = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_LIMIT = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_TALL = 3'd7;

	localparam logic [7:0] LINES_SHORT = 8'd224;
	localparam logic [7:0] LINES_TALL = 8'd240;

	localparam logic [15:0] DAMPING_RESET = 16'd64;

	// per-frame speed of each group, signed 2.6 pixels
	localparam logic signed [7:0] GROUP_SPEED [GROUP_COUNT] =
		'{-8'sd102, -8'sd76, -8'sd54, -8'sd35, -8'sd22};
	// cumulative map rows owned, counted upward from the bottom row
	localparam logic [6:0] GROUP_LIMIT [GROUP_COUNT] =
		'{7'd6, 7'd14, 7'd22, 7'd26, 7'd32};

	typedef enum logic [2:0] {
		OP_TICK,
		OP_PULSE,
		OP_STACK,
		OP_QUERY,
		OP_REPORT
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] arg;
	} cmd_t;

	typedef struct packed {
		logic [15:0] stiffness;
		logic [15:0] damping;
		logic [15:0] imp_soft;
		logic [15:0] imp_softdrop;
		logic [15:0] imp_harddrop;
		logic [14:0] rest;
		logic [14:0] limit;
		logic        tall;
	} cfg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MULK,
		BK_MULD,
		BK_APPLY
	} bk_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/parallax_spring_line_scroll.sv
// Parallax line-scroll background with a damped vertical spring.
//
// Input channel (in_valid / in_stall) carries one event per transaction:
// frame tick, pulse, stack-top update or line query. Every input transaction
// gives exactly one result transaction on out_valid / out_stall with the
// vertical scroll in pixels, the queried line's horizontal scroll and the
// current speed scale. Registers are written over cfg_valid / cfg_ready,
// which is always ready; write them only while no transaction is in flight.
//
// Pulse, stack-top and query results pass through the command queue and
// the output register; a tick also runs the spring steps MULK, MULD and
// APPLY, the first two on the shared 17x16 multiplier. Throughput: one
// non-tick event per cycle while out_stall is low; none while a tick runs.
//
// A two-entry command queue sits between the classifier and the datapath;
// in_stall rises when it is full. A stalled result holds in the output
// register while the classifier keeps filling the queue. Reset clears all
// scroll state and sets damping to 1.0 and all other registers to zero.
`default_nettype none

`include "parallax_spring_line_scroll_macros.svh"

module parallax_spring_line_scroll
	import psls_pkg::*;
#(
	parameter int BOARD_ROWS = 20,
	parameter int MAP_ROWS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [15:0]            cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             func,
	input  wire logic [1:0]             pulse_kind,
	input  wire logic                   pulse_mode_ok,
	input  wire logic                   pulse_active,
	input  wire logic signed [7:0]      top_row,
	input  wire logic [7:0]             line_number,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [8:0]                  vertical_scroll_px,
	output logic signed [9:0]           line_hscroll,
	output logic [6:0]                  speed_level
);

	cfg_t cfg_q;
	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cmd_t q_cmd;
	logic [9:0] hs_raw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{stiffness: '0, damping: DAMPING_RESET, imp_soft: '0,
				imp_softdrop: '0, imp_harddrop: '0, rest: '0, limit: '0, tall: 1'b0};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STIFFNESS:    cfg_q.stiffness <= cfg_data;
				REG_DAMPING:      cfg_q.damping <= cfg_data;
				REG_IMP_SOFT:     cfg_q.imp_soft <= cfg_data;
				REG_IMP_SOFTDROP: cfg_q.imp_softdrop <= cfg_data;
				REG_IMP_HARDDROP: cfg_q.imp_harddrop <= cfg_data;
				REG_REST:         cfg_q.rest <= cfg_data[14:0];
				REG_LIMIT:        cfg_q.limit <= cfg_data[14:0];
				REG_TALL:         cfg_q.tall <= cfg_data[0];
			endcase
		end
	end

	psls_front #(
		.BOARD_ROWS(BOARD_ROWS)
	) u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.pulse_kind    (pulse_kind),
		.pulse_mode_ok (pulse_mode_ok),
		.pulse_active  (pulse_active),
		.top_row       (top_row),
		.line_number   (line_number),
		.cfg           (cfg_q),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	psls_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.cmd      (q_cmd)
	);

	psls_back #(
		.MAP_ROWS(MAP_ROWS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.q_valid            (q_valid),
		.q_cmd              (q_cmd),
		.q_pop              (q_pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.vertical_scroll_px (vertical_scroll_px),
		.line_hscroll       (hs_raw),
		.speed_level        (speed_level)
	);

	assign line_hscroll = signed'(hs_raw);

	// a non-tick command produces its result in the next cycle
	`PSLS_ASSERT_AFTER(a_fast_result, q_pop && q_cmd.op != OP_TICK, 1, out_valid, "non-tick result missing")
	// a tick leaves the output empty and takes no command in the MULK step
	`PSLS_ASSERT_AFTER(a_tick_gap, q_pop && q_cmd.op == OP_TICK, 1, !out_valid && !q_pop, "tick overlapped")
	// and its result appears after the last spring step
	`PSLS_ASSERT_AFTER(a_tick_result, q_pop && q_cmd.op == OP_TICK, 4, out_valid, "tick result missing")
	`PSLS_ASSERT_NOW(a_speed_range, out_valid, speed_level <= 7'(FULL_SPEED), "speed above full")

endmodule

`default_nettype wire

>>> hw/rtl/psls_front.sv
`default_nettype none

module psls_front
	import psls_pkg::*;
#(
	parameter int BOARD_ROWS = 20
) (
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        func,
	input  wire logic [1:0]        pulse_kind,
	input  wire logic              pulse_mode_ok,
	input  wire logic              pulse_active,
	input  wire logic signed [7:0] top_row,
	input  wire logic [7:0]        line_number,
	input  wire cfg_t              cfg,
	input  wire logic              q_full,
	output logic                   push,
	output cmd_t                   push_cmd
);

	localparam int ROW_W = (BOARD_ROWS > 1) ? $clog2(BOARD_ROWS) : 1;

	logic [6:0] scale_tab [BOARD_ROWS];
	logic       row_in_range;
	logic [6:0] scale_sel;
	logic [7:0] height;

	// fill to speed scale, one entry per board row
	for (genvar r = 0; r < BOARD_ROWS; r++) begin : g_scale
		localparam int Q = ((BOARD_ROWS - r) * FULL_SPEED) / (BOARD_ROWS - 2);
		assign scale_tab[r] = 7'((Q > FULL_SPEED) ? FULL_SPEED : Q);
	end

	assign row_in_range = !top_row[7] && (top_row[6:0] < 7'(BOARD_ROWS));
	assign scale_sel = row_in_range ? scale_tab[top_row[ROW_W-1:0]] : 7'd0;
	assign height = cfg.tall ? LINES_TALL : LINES_SHORT;

	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	always_comb begin
		push_cmd.op = OP_REPORT;
		push_cmd.arg = '0;
		unique case (func)
			FUNC_TICK: begin
				push_cmd.op = OP_TICK;
			end
			FUNC_PULSE: begin
				if (pulse_mode_ok && pulse_active && pulse_kind != KIND_NONE) begin
					push_cmd.op = OP_PULSE;
					case (pulse_kind)
						KIND_SOFT:     push_cmd.arg = cfg.imp_soft;
						KIND_SOFTDROP: push_cmd.arg = cfg.imp_softdrop;
						default:       push_cmd.arg = cfg.imp_harddrop;
					endcase
				end
			end
			FUNC_STACK: begin
				push_cmd.op = OP_STACK;
				push_cmd.arg = {9'd0, scale_sel};
			end
			FUNC_QUERY: begin
				// lines past the visible height report zero scroll
				if (line_number < height) begin
					push_cmd.op = OP_QUERY;
					push_cmd.arg = {8'd0, line_number};
				end
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/psls_queue.sv
`default_nettype none

module psls_queue
	import psls_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      valid,
	output cmd_t      cmd
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/psls_back.sv
`default_nettype none

module psls_back
	import psls_pkg::*;
#(
	parameter int MAP_ROWS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic q_valid,
	input  wire cmd_t q_cmd,
	output logic      q_pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [8:0] vertical_scroll_px,
	output logic [9:0] line_hscroll,
	output logic [6:0] speed_level
);

	localparam logic [6:0] ROW_MAX = 7'(MAP_ROWS - 1);

	bk_state_t state_q, state_d;

	logic [15:0] grp_q [GROUP_COUNT];
	logic [15:0] off_q;
	logic [15:0] vel_q;
	logic [14:0] pos_q;
	logic [6:0]  scale_q;

	logic signed [32:0] prod_q;
	logic               out_valid_q;
	logic [8:0]         px_q;
	logic [9:0]         hs_q;
	logic [6:0]         spd_q;

	// fsm outputs
	logic ld_out;
	logic sel_damp;
	logic do_grp;
	logic do_apply;
	logic slot_free;

	logic signed [15:0] grp_prod [GROUP_COUNT];
	logic [15:0]        grp_next [GROUP_COUNT];

	logic signed [16:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [32:0] mul_p;
	logic [15:0]        v_acc;

	logic [15:0] v_new, off_sum, pos_sum;
	logic [14:0] pos_cl;
	logic [15:0] off_cl, vel_cl;

	logic [9:0] y_line;
	logic [6:0] row_sat, depth;
	logic [9:0] hs_query;

	logic [8:0] px_d;
	logic [9:0] hs_d;
	logic [6:0] spd_d;

	assign slot_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (q_valid && slot_free && q_cmd.op == OP_TICK) state_d = BK_MULK;
			BK_MULK:  state_d = BK_MULD;
			BK_MULD:  state_d = BK_APPLY;
			BK_APPLY: state_d = BK_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		q_pop = 1'b0;
		ld_out = 1'b0;
		sel_damp = 1'b0;
		do_grp = 1'b0;
		do_apply = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop = q_valid && slot_free;
				ld_out = q_valid && slot_free && q_cmd.op != OP_TICK;
			end
			BK_MULK: begin
				do_grp = 1'b1;
			end
			BK_MULD: begin
				sel_damp = 1'b1;
			end
			BK_APPLY: begin
				do_apply = 1'b1;
				ld_out = 1'b1;
			end
		endcase
	end

	// parallax groups, one small multiplier per lane
	always_comb begin
		for (int g = 0; g < GROUP_COUNT; g++) begin
			grp_prod[g] = GROUP_SPEED[g] * signed'({1'b0, scale_q});
			grp_next[g] = grp_q[g] + {{6{grp_prod[g][15]}}, grp_prod[g][15:6]};
		end
	end

	// shared multiplier: -offset * stiffness, then updated velocity * damping
	assign v_acc = vel_q + prod_q[21:6];
	always_comb begin
		if (sel_damp) begin
			mul_a = signed'({v_acc[15], v_acc});
			mul_b = signed'(cfg.damping);
		end else begin
			mul_a = -signed'({off_q[15], off_q});
			mul_b = signed'(cfg.stiffness);
		end
	end
	assign mul_p = mul_a * mul_b;

	// spring step and clamp to 0..limit
	always_comb begin
		v_new = prod_q[21:6];
		off_sum = off_q + v_new;
		pos_sum = {1'b0, cfg.rest} + off_sum;
		if (pos_sum[15]) begin
			pos_cl = '0;
			off_cl = 16'd0 - {1'b0, cfg.rest};
			vel_cl = v_new[15] ? 16'd0 : v_new;
		end else if (pos_sum[14:0] > cfg.limit) begin
			pos_cl = cfg.limit;
			off_cl = {1'b0, cfg.limit} - {1'b0, cfg.rest};
			vel_cl = (!v_new[15] && v_new != 16'd0) ? 16'd0 : v_new;
		end else begin
			pos_cl = pos_sum[14:0];
			off_cl = off_sum;
			vel_cl = v_new;
		end
	end

	// screen line to map row to group
	assign y_line = {1'b0, pos_q[14:6]} + {2'b00, q_cmd.arg[7:0]};
	assign row_sat = (y_line[9:3] > ROW_MAX) ? ROW_MAX : y_line[9:3];
	assign depth = ROW_MAX - row_sat;

	always_comb begin
		hs_query = '0;
		// walk down so the lowest matching group wins
		for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
			if (depth < GROUP_LIMIT[g]) hs_query = grp_q[g][15:6];
		end
	end

	assign px_d = do_apply ? pos_cl[14:6] : pos_q[14:6];
	assign spd_d = (q_pop && q_cmd.op == OP_STACK) ? q_cmd.arg[6:0] : scale_q;
	assign hs_d = (q_pop && q_cmd.op == OP_QUERY) ? hs_query : 10'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			for (int g = 0; g < GROUP_COUNT; g++) grp_q[g] <= '0;
			off_q <= '0;
			vel_q <= '0;
			pos_q <= '0;
			scale_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_grp) begin
				for (int g = 0; g < GROUP_COUNT; g++) grp_q[g] <= grp_next[g];
			end
			if (do_apply) begin
				off_q <= off_cl;
				vel_q <= vel_cl;
				pos_q <= pos_cl;
			end
			if (q_pop && q_cmd.op == OP_PULSE) vel_q <= vel_q + q_cmd.arg;
			if (q_pop && q_cmd.op == OP_STACK) scale_q <= q_cmd.arg[6:0];
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (ld_out) begin
			px_q <= px_d;
			hs_q <= hs_d;
			spd_q <= spd_d;
		end
	end

	assign out_valid = out_valid_q;
	assign vertical_scroll_px = px_q;
	assign line_hscroll = hs_q;
	assign speed_level = spd_q;

endmodule

`default_nettype wire
